// File: hw/rtl/tempo_map_time_conversion_assert.svh
// assertion macros for the tempo map block
`ifndef TEMPO_MAP_TIME_CONVERSION_ASSERT_SVH
`define TEMPO_MAP_TIME_CONVERSION_ASSERT_SVH

// same-cycle implication
`define TMTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tempo map assertion failed");

// next-cycle implication
`define TMTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tempo map assertion failed");

`endif

// File: hw/rtl/tmtc_pkg.sv
// shared constants and types for the tempo map block
package tmtc_pkg;

	localparam int MAX_ENTRIES = 32;
	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int NW = $clog2(MAX_ENTRIES + 1);
	localparam int DW = 50;
	localparam int CW = $clog2(DW + 1);

	localparam logic [15:0] DEFAULT_BPM = 16'd15360;
	localparam logic [15:0] SEC_PER_BEAT_K = 16'd7680;
	localparam logic [33:0] SECONDS_MAX = 34'h3_FFFF_FFFF;
	localparam logic [31:0] BEATS_MAX = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		MODE_LOAD    = 2'd0,
		MODE_BPM     = 2'd1,
		MODE_TO_SEC  = 2'd2,
		MODE_TO_BEAT = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_FULL       = 3'd1,
		ST_ZERO_BPM   = 3'd2,
		ST_OUT_ORDER  = 3'd3,
		ST_SATURATED  = 3'd4
	} status_t;

endpackage

// File: hw/rtl/tmtc_ram.sv
// generic single-port-write ram with registered read
module tmtc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/tempo_map_time_conversion.sv
// tempo map: table load and beat, bpm and seconds conversions
//
//  channel   handshake      payload
//  command   start / busy   mode restart_table entry_beat entry_bpm query_beats query_seconds
//  result    done           bpm_out seconds_out beats_out status
//
// a load gives its result the cycle after it is taken and leaves busy low
// a query walks the table one ram read per entry, through fetch, wait and eval states,
// plus the shared restoring divider for each segment time and final quotient
// reset leaves one entry at beat zero, 120 bpm; results cannot be stalled
`include "tempo_map_time_conversion_assert.svh"

module tempo_map_time_conversion (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic        restart_table,
	input  logic [31:0] entry_beat,
	input  logic [15:0] entry_bpm,
	input  logic [31:0] query_beats,
	input  logic [33:0] query_seconds,
	output logic        done,
	output logic [15:0] bpm_out,
	output logic [33:0] seconds_out,
	output logic [31:0] beats_out,
	output logic [2:0]  status
);

	typedef enum logic [2:0] {
		S_IDLE, S_FETCH, S_WAITD, S_EVAL, S_DIV, S_POST
	} state_t;

	state_t                   state_q;
	tmtc_pkg::mode_t          mode_q;
	logic [tmtc_pkg::NW-1:0]  n_q;
	logic [tmtc_pkg::NW-1:0]  i_q;
	logic [31:0]              last_beat_q;
	logic [15:0]              bpm0_q;
	logic [31:0]              cur_beat_q;
	logic [15:0]              cur_bpm_q;
	logic                     has_next_q;
	logic                     last_q;
	logic                     fin_q;
	logic [31:0]              qbeat_q;
	logic [33:0]              remain_q;
	logic [51:0]              acc_q;
	logic [tmtc_pkg::DW-1:0]  quot_q;
	logic [15:0]              rem_q;
	logic [15:0]              den_q;
	logic [tmtc_pkg::CW-1:0]  cnt_q;
	logic                     done_q;
	logic [15:0]              bpm_out_q;
	logic [33:0]              seconds_out_q;
	logic [31:0]              beats_out_q;
	tmtc_pkg::status_t        status_q;

	logic                     accept;
	logic                     ld_we;
	tmtc_pkg::status_t        ld_status;
	logic [tmtc_pkg::NW-1:0]  nxt_idx;
	logic [47:0]              rdata;
	logic [31:0]              nb;
	logic [15:0]              nbpm;
	logic [31:0]              top;
	logic [31:0]              seg_len;
	logic [tmtc_pkg::DW-1:0]  seg_num;
	logic [tmtc_pkg::DW-1:0]  fin_num;
	logic [tmtc_pkg::DW-1:0]  prod;
	logic [16:0]              trial;
	logic [50:0]              res;

	assign accept  = start && !busy;
	assign nxt_idx = i_q + tmtc_pkg::NW'(1);
	assign nb      = rdata[47:16];
	assign nbpm    = rdata[15:0];

	// load checks, full before zero bpm before order; a restart checks only zero bpm
	always_comb begin
		ld_we = 1'b0;
		ld_status = tmtc_pkg::ST_OK;
		if (restart_table) begin
			if (entry_bpm == 16'd0) begin
				ld_status = tmtc_pkg::ST_ZERO_BPM;
			end
		end else if (n_q >= tmtc_pkg::NW'(tmtc_pkg::MAX_ENTRIES)) begin
			ld_status = tmtc_pkg::ST_FULL;
		end else if (entry_bpm == 16'd0) begin
			ld_status = tmtc_pkg::ST_ZERO_BPM;
		end else if (entry_beat <= last_beat_q) begin
			ld_status = tmtc_pkg::ST_OUT_ORDER;
		end else begin
			ld_we = 1'b1;
		end
	end

	// entry zero lives in registers, the ram holds entries one and up
	tmtc_ram #(
		.WIDTH(48),
		.DEPTH(tmtc_pkg::MAX_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (accept && (mode == tmtc_pkg::MODE_LOAD) && ld_we),
		.waddr(n_q[tmtc_pkg::IW-1:0]),
		.wdata({entry_beat, entry_bpm}),
		.re   (state_q == S_FETCH),
		.raddr(nxt_idx[tmtc_pkg::IW-1:0]),
		.rdata(rdata)
	);

	always_comb begin
		top = (has_next_q && (nb < qbeat_q)) ? nb : qbeat_q;
		seg_len = top - cur_beat_q;
		if (mode_q == tmtc_pkg::MODE_TO_BEAT) begin
			seg_len = nb - cur_beat_q;
		end
		// len * 7680 as len * 8192 - len * 512, plus half the divisor
		seg_num = tmtc_pkg::DW'({seg_len, 13'b0}) - tmtc_pkg::DW'({seg_len, 9'b0})
			+ tmtc_pkg::DW'(cur_bpm_q[15:1]);
		prod = {16'b0, remain_q} * {34'b0, cur_bpm_q};
		fin_num = prod + tmtc_pkg::DW'(tmtc_pkg::SEC_PER_BEAT_K[15:1]);
		trial = {rem_q, quot_q[tmtc_pkg::DW-1]};
		res = 51'(cur_beat_q) + 51'(quot_q);
		if (has_next_q && (res > 51'(nb))) begin
			res = 51'(nb);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= tmtc_pkg::MODE_LOAD;
			n_q <= tmtc_pkg::NW'(1);
			i_q <= '0;
			last_beat_q <= '0;
			bpm0_q <= tmtc_pkg::DEFAULT_BPM;
			cur_beat_q <= '0;
			cur_bpm_q <= '0;
			has_next_q <= 1'b0;
			last_q <= 1'b0;
			fin_q <= 1'b0;
			qbeat_q <= '0;
			remain_q <= '0;
			acc_q <= '0;
			quot_q <= '0;
			rem_q <= '0;
			den_q <= '0;
			cnt_q <= '0;
			done_q <= 1'b0;
			bpm_out_q <= '0;
			seconds_out_q <= '0;
			beats_out_q <= '0;
			status_q <= tmtc_pkg::ST_OK;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q <= tmtc_pkg::mode_t'(mode);
						qbeat_q <= query_beats;
						remain_q <= query_seconds;
						acc_q <= '0;
						i_q <= '0;
						cur_beat_q <= '0;
						cur_bpm_q <= bpm0_q;
						fin_q <= 1'b0;
						if (mode == tmtc_pkg::MODE_LOAD) begin
							done_q <= 1'b1;
							bpm_out_q <= '0;
							seconds_out_q <= '0;
							beats_out_q <= '0;
							status_q <= ld_status;
							if (restart_table && (entry_bpm != 16'd0)) begin
								bpm0_q <= entry_bpm;
								n_q <= tmtc_pkg::NW'(1);
								last_beat_q <= '0;
							end else if (ld_we) begin
								n_q <= n_q + tmtc_pkg::NW'(1);
								last_beat_q <= entry_beat;
							end
						end else begin
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: begin
					has_next_q <= nxt_idx < n_q;
					state_q <= (nxt_idx < n_q) ? S_WAITD : S_EVAL;
				end
				S_WAITD: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					case (mode_q)
						tmtc_pkg::MODE_BPM: begin
							if (has_next_q && (nb <= qbeat_q)) begin
								cur_beat_q <= nb;
								cur_bpm_q <= nbpm;
								i_q <= nxt_idx;
								state_q <= S_FETCH;
							end else begin
								done_q <= 1'b1;
								bpm_out_q <= cur_bpm_q;
								seconds_out_q <= '0;
								beats_out_q <= '0;
								status_q <= tmtc_pkg::ST_OK;
								state_q <= S_IDLE;
							end
						end
						tmtc_pkg::MODE_TO_SEC: begin
							last_q <= top >= qbeat_q;
							if (top > cur_beat_q) begin
								quot_q <= seg_num;
								rem_q <= '0;
								den_q <= cur_bpm_q;
								cnt_q <= tmtc_pkg::CW'(tmtc_pkg::DW);
								state_q <= S_DIV;
							end else begin
								quot_q <= '0;
								state_q <= S_POST;
							end
						end
						default: begin
							rem_q <= '0;
							cnt_q <= tmtc_pkg::CW'(tmtc_pkg::DW);
							state_q <= S_DIV;
							if (has_next_q) begin
								quot_q <= seg_num;
								den_q <= cur_bpm_q;
							end else begin
								fin_q <= 1'b1;
								quot_q <= fin_num;
								den_q <= tmtc_pkg::SEC_PER_BEAT_K;
							end
						end
					endcase
				end
				S_DIV: begin
					// one restoring step per cycle
					if (trial >= {1'b0, den_q}) begin
						rem_q <= 16'(trial - {1'b0, den_q});
						quot_q <= {quot_q[tmtc_pkg::DW-2:0], 1'b1};
					end else begin
						rem_q <= trial[15:0];
						quot_q <= {quot_q[tmtc_pkg::DW-2:0], 1'b0};
					end
					cnt_q <= cnt_q - tmtc_pkg::CW'(1);
					if (cnt_q == tmtc_pkg::CW'(1)) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					if (mode_q == tmtc_pkg::MODE_TO_SEC) begin
						if (last_q) begin
							done_q <= 1'b1;
							bpm_out_q <= '0;
							beats_out_q <= '0;
							if ((acc_q + 52'(quot_q)) > 52'(tmtc_pkg::SECONDS_MAX)) begin
								seconds_out_q <= tmtc_pkg::SECONDS_MAX;
								status_q <= tmtc_pkg::ST_SATURATED;
							end else begin
								seconds_out_q <= 34'(acc_q + 52'(quot_q));
								status_q <= tmtc_pkg::ST_OK;
							end
							state_q <= S_IDLE;
						end else begin
							acc_q <= acc_q + 52'(quot_q);
							cur_beat_q <= nb;
							cur_bpm_q <= nbpm;
							i_q <= nxt_idx;
							state_q <= S_FETCH;
						end
					end else if (fin_q) begin
						done_q <= 1'b1;
						bpm_out_q <= '0;
						seconds_out_q <= '0;
						if (res > 51'(tmtc_pkg::BEATS_MAX)) begin
							beats_out_q <= tmtc_pkg::BEATS_MAX;
							status_q <= tmtc_pkg::ST_SATURATED;
						end else begin
							beats_out_q <= res[31:0];
							status_q <= tmtc_pkg::ST_OK;
						end
						state_q <= S_IDLE;
					end else if (tmtc_pkg::DW'(remain_q) <= quot_q) begin
						fin_q <= 1'b1;
						quot_q <= fin_num;
						rem_q <= '0;
						den_q <= tmtc_pkg::SEC_PER_BEAT_K;
						cnt_q <= tmtc_pkg::CW'(tmtc_pkg::DW);
						state_q <= S_DIV;
					end else begin
						remain_q <= 34'(tmtc_pkg::DW'(remain_q) - quot_q);
						cur_beat_q <= nb;
						cur_bpm_q <= nbpm;
						i_q <= nxt_idx;
						state_q <= S_FETCH;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = state_q != S_IDLE;
	assign done        = done_q;
	assign bpm_out     = bpm_out_q;
	assign seconds_out = seconds_out_q;
	assign beats_out   = beats_out_q;
	assign status      = status_q;

	`TMTC_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy)
	`TMTC_ASSERT_NEXT(a_query_busy, clk, arst_n, accept && (mode != tmtc_pkg::MODE_LOAD), busy)
	`TMTC_ASSERT_NOW(a_fill_range, clk, arst_n, 1'b1,
		(n_q >= tmtc_pkg::NW'(1)) && (n_q <= tmtc_pkg::NW'(tmtc_pkg::MAX_ENTRIES)))

endmodule
